// File: hw/rtl/hslc_pkg.sv
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared widths, constants and types for the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hslc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int HUE_W      = 10;
  localparam int HUE_CL_W   = 9;
  localparam int UNIT_W     = 16;
  localparam int UNIT_FRAC  = 15;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 24;
  localparam int NUM_LANES  = 3;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam int HUE_MAX        = 360;
  localparam int UNIT_MAX       = 32768;
  localparam int HUE_RECIP_SHIFT = 9;

  localparam int Q_DEPTH = 2;

  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_TOP,
    SEG_FALL,
    SEG_BASE
  } seg_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

endpackage

// File: hw/rtl/hslc_front.sv
// ----------------------------------------------------------------------------
// hslc_front
// Input classification: clamp the HSL fields, convert to fixed point, form
// the coarse hue quotient and the lightness-saturation product.
// ----------------------------------------------------------------------------
module hslc_front import hslc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [IN_TDATA_W-1:0]                          in_tdata,
  output logic [HUE_CL_W+4*(FRAC_BITS+1)-1:0]           q_data
);

  localparam int FW    = FRAC_BITS + 1;
  localparam int RW    = FRAC_BITS + 1;
  localparam logic [RW-1:0] HUE_RECIP =
    RW'((64'd1 << (FRAC_BITS + HUE_RECIP_SHIFT)) / HUE_MAX);

  logic [HUE_W-1:0]            hue_raw;
  logic [UNIT_W-1:0]           sat_raw;
  logic [UNIT_W-1:0]           light_raw;
  logic [HUE_CL_W-1:0]         hue_cl;
  logic [UNIT_W-1:0]           sat_cl;
  logic [UNIT_W-1:0]           light_cl;
  logic [UNIT_W+FRAC_BITS-1:0] sat_ext;
  logic [UNIT_W+FRAC_BITS-1:0] light_ext;
  logic [FW-1:0]               sat_fx;
  logic [FW-1:0]               light_fx;
  logic [HUE_CL_W+RW-1:0]      hue_prod;
  logic [FW-1:0]               hue_coarse;
  logic [2*FW-1:0]             ls_prod;
  logic [FW-1:0]               ls_fx;

  assign hue_raw   = in_tdata[HUE_W-1:0];
  assign sat_raw   = in_tdata[HUE_W +: UNIT_W];
  assign light_raw = in_tdata[HUE_W+UNIT_W +: UNIT_W];

  assign hue_cl   = (hue_raw > HUE_W'(HUE_MAX)) ? HUE_CL_W'(HUE_MAX) : hue_raw[HUE_CL_W-1:0];
  assign sat_cl   = (sat_raw > UNIT_W'(UNIT_MAX)) ? UNIT_W'(UNIT_MAX) : sat_raw;
  assign light_cl = (light_raw > UNIT_W'(UNIT_MAX)) ? UNIT_W'(UNIT_MAX) : light_raw;

  assign sat_ext   = {sat_cl, {FRAC_BITS{1'b0}}};
  assign light_ext = {light_cl, {FRAC_BITS{1'b0}}};
  assign sat_fx    = sat_ext[UNIT_FRAC +: FW];
  assign light_fx  = light_ext[UNIT_FRAC +: FW];

  assign hue_prod   = HUE_CL_W'(hue_cl) * RW'(HUE_RECIP);
  assign hue_coarse = hue_prod[HUE_RECIP_SHIFT +: FW];

  assign ls_prod = light_fx * sat_fx;
  assign ls_fx   = ls_prod[FRAC_BITS +: FW];

  assign q_data = {ls_fx, sat_fx, light_fx, hue_coarse, hue_cl};

endmodule

// File: hw/rtl/hslc_queue.sv
// ----------------------------------------------------------------------------
// hslc_queue
// Short register queue between the front classifier and the back pipeline.
// ----------------------------------------------------------------------------
module hslc_queue import hslc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push;
  logic             pop;

  assign stat.not_full  = (count_r != CW'(Q_DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign push           = push_valid && stat.not_full;
  assign pop            = pop_ready && stat.not_empty;
  assign pop_data       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/hslc_back.sv
// ----------------------------------------------------------------------------
// hslc_back
// Conversion pipeline: hue correction, channel hue wrap, segment select,
// segment interpolation product and byte scaling, one item per clock while the output is not stalled.
// ----------------------------------------------------------------------------
module hslc_back import hslc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [HUE_CL_W+4*(FRAC_BITS+1)-1:0]    q_data,
  input  q_stat_t                                q_stat,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [OUT_TDATA_W-1:0]                 out_tdata
);

  localparam int FW = FRAC_BITS + 1;
  localparam int XW = FRAC_BITS + 4;
  localparam int MW = FRAC_BITS + 11;

  localparam logic [FW-1:0] ONE        = FW'(1) << FRAC_BITS;
  localparam logic [FW-1:0] HALF       = FW'(1) << (FRAC_BITS - 1);
  localparam logic [FW-1:0] THIRD      = FW'((2 ** FRAC_BITS) / 3);
  localparam logic [FW-1:0] TWO_THIRDS = FW'((2 * (2 ** FRAC_BITS)) / 3);
  localparam logic [XW-1:0] ONE_X      = XW'(ONE);
  localparam logic [XW-1:0] TWO_ONE_X  = XW'(ONE) << 1;

  logic [HUE_CL_W-1:0] q_hue_cl;
  logic [FW-1:0]       q_hue_coarse;
  logic [FW-1:0]       q_light;
  logic [FW-1:0]       q_sat;
  logic [FW-1:0]       q_ls;
  logic                advance;

  logic                s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic                out_vld_r;

  logic [FW-1:0]       hue_r, hue_nxt;
  logic [FW-1:0]       v1_r, v1_nxt;
  logic [FW-1:0]       v2_r, v2_nxt;
  logic [FW-1:0]       d_r, d_nxt;

  logic [FW-1:0]       s2_v1_r, s2_v2_r, s2_d_r;
  logic [FW-1:0]       t_r   [NUM_LANES];
  logic [FW-1:0]       t_nxt [NUM_LANES];

  logic [FW-1:0]       s3_v1_r, s3_v2_r, s3_d_r;
  seg_t                seg_r   [NUM_LANES];
  seg_t                seg_nxt [NUM_LANES];
  logic [FW-1:0]       fac_r   [NUM_LANES];
  logic [FW-1:0]       fac_nxt [NUM_LANES];

  logic [FW-1:0]       s4_v1_r, s4_v2_r;
  seg_t                s4_seg_r [NUM_LANES];
  logic [FW-1:0]       ramp_r   [NUM_LANES];
  logic [FW-1:0]       ramp_nxt [NUM_LANES];

  logic [CH_W-1:0]     byte_r   [NUM_LANES];
  logic [CH_W-1:0]     byte_nxt [NUM_LANES];

  assign {q_ls, q_sat, q_light, q_hue_coarse, q_hue_cl} = q_data;

  assign advance    = !out_vld_r || out_tready;
  assign q_pop      = advance;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {byte_r[LANE_RED], byte_r[LANE_GREEN], byte_r[LANE_BLUE],
                       byte_r[LANE_BLUE], byte_r[LANE_GREEN], byte_r[LANE_RED]};

  always_comb begin
    logic [FW:0]   q_inc;
    logic [MW-1:0] q_inc_scaled;
    logic [MW-1:0] hue_num;
    logic [FW:0]   v2_wide;
    logic [FW:0]   v1_wide;
    q_inc        = {1'b0, q_hue_coarse} + 1'b1;
    q_inc_scaled = MW'(q_inc) * MW'(HUE_MAX);
    hue_num      = MW'({q_hue_cl, {FRAC_BITS{1'b0}}});
    hue_nxt      = (q_inc_scaled <= hue_num) ? q_inc[FW-1:0] : q_hue_coarse;
    if (q_light < HALF) begin
      v2_wide = {1'b0, q_light} + {1'b0, q_ls};
    end else begin
      v2_wide = {1'b0, q_light} + {1'b0, q_sat} - {1'b0, q_ls};
    end
    v2_nxt  = v2_wide[FW-1:0];
    v1_wide = {q_light, 1'b0} - {1'b0, v2_nxt};
    v1_nxt  = v1_wide[FW-1:0];
    d_nxt   = v2_nxt - v1_nxt;
  end

  always_comb begin
    logic [FW:0] red_sum;
    red_sum = {1'b0, hue_r} + {1'b0, THIRD};
    t_nxt[LANE_RED]   = (red_sum > {1'b0, ONE}) ? FW'(red_sum - {1'b0, ONE}) : red_sum[FW-1:0];
    t_nxt[LANE_GREEN] = hue_r;
    t_nxt[LANE_BLUE]  = (hue_r >= THIRD) ? (hue_r - THIRD) : (hue_r + ONE - THIRD);
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      seg_nxt[i] = SEG_BASE;
      fac_nxt[i] = '0;
      if ((XW'(t_r[i]) * XW'(6)) < ONE_X) begin
        seg_nxt[i] = SEG_RISE;
        fac_nxt[i] = FW'(XW'(t_r[i]) * XW'(6));
      end else if ((XW'(t_r[i]) << 1) < ONE_X) begin
        seg_nxt[i] = SEG_TOP;
      end else if ((XW'(t_r[i]) * XW'(3)) < TWO_ONE_X) begin
        seg_nxt[i] = SEG_FALL;
        fac_nxt[i] = FW'(XW'(TWO_THIRDS - t_r[i]) * XW'(6));
      end
    end
  end

  always_comb begin
    logic [2*FW-1:0] prod;
    prod = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      prod        = s3_d_r * fac_r[i];
      ramp_nxt[i] = prod[FRAC_BITS +: FW];
    end
  end

  always_comb begin
    logic [FW:0]      val;
    logic [FW-1:0]    val_cl;
    logic [FW+7:0]    scaled;
    val    = '0;
    val_cl = '0;
    scaled = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      unique case (s4_seg_r[i])
        SEG_RISE, SEG_FALL: val = {1'b0, s4_v1_r} + {1'b0, ramp_r[i]};
        SEG_TOP:            val = {1'b0, s4_v2_r};
        SEG_BASE:           val = {1'b0, s4_v1_r};
        default:            val = {1'b0, s4_v1_r};
      endcase
      val_cl      = (val > {1'b0, ONE}) ? ONE : val[FW-1:0];
      scaled      = {val_cl, 8'b0} - (FW+8)'(val_cl);
      byte_nxt[i] = scaled[FRAC_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= q_stat.not_empty;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hue_r   <= hue_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      d_r     <= d_nxt;
      s2_v1_r <= v1_r;
      s2_v2_r <= v2_r;
      s2_d_r  <= d_r;
      s3_v1_r <= s2_v1_r;
      s3_v2_r <= s2_v2_r;
      s3_d_r  <= s2_d_r;
      s4_v1_r <= s3_v1_r;
      s4_v2_r <= s3_v2_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        t_r[i]      <= t_nxt[i];
        seg_r[i]    <= seg_nxt[i];
        fac_r[i]    <= fac_nxt[i];
        s4_seg_r[i] <= seg_r[i];
        ramp_r[i]   <= ramp_nxt[i];
        byte_r[i]   <= byte_nxt[i];
      end
    end
  end

  a_hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (hue_r <= ONE))
    else $error("corrected hue exceeds one");

  a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ((v1_r <= v2_r) && (v2_r <= ONE) && (d_r == v2_r - v1_r)))
    else $error("segment levels out of order");

  a_lane_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> ((t_r[LANE_RED] <= ONE) && (t_r[LANE_GREEN] <= ONE) &&
                  (t_r[LANE_BLUE] <= ONE)))
    else $error("channel hue not wrapped");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(byte_r[LANE_RED]) &&
                                    $stable(s4_vld_r)))
    else $error("pipeline moved during stall");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_vld_r && advance) |=> out_vld_r)
    else $error("item lost at output register");

endmodule

// File: hw/rtl/hsl_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_top
// HSL to RGB pixel converter, one result item per input item.
// ----------------------------------------------------------------------------
// Takes one HSL item per clock and returns one RGB item per clock when the
// output is not stalled. From input accept to output valid, an item passes
// through the input queue and then the conversion pipeline registers to its
// output register. The pipeline takes a new item every clock because each
// stage holds one item and all stages advance together whenever the output
// register is free or being drained. A two-entry queue between the input
// classifier and the pipeline takes up to two more items while a finished
// item waits on the output register; once it is full, in_tready returns in
// the cycle after the output side resumes.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_top import hslc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // hue_degrees, saturation, lightness
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // red, green, blue, packed_rgb
);

  localparam int QW = HUE_CL_W + 4 * (FRAC_BITS + 1);

  logic [QW-1:0] front_data;
  logic [QW-1:0] q_data;
  logic          q_pop;
  q_stat_t       q_stat;

  assign in_tready = q_stat.not_full;

  hslc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_tdata (in_tdata),
    .q_data   (front_data)
  );

  hslc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_data  (front_data),
    .pop_ready  (q_pop),
    .pop_data   (q_data),
    .stat       (q_stat)
  );

  hslc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
